### hw/rtl/mbsp_pkg.sv
package mbsp_pkg;

    localparam int MODE_W   = 2;
    localparam int TICK_W   = 32;
    localparam int SEL_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int MAX_CH   = 8;
    localparam int BUFIDX_W = 2;
    localparam int SLOT_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DEF_CHANNELS         = 8;
    localparam int DEF_BUFFERS          = 4;
    localparam int DEF_WORDS_PER_BUFFER = 256;

    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TAKE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CH_ENABLE = 2'd2;

    localparam logic [15:0] RST_DIVIDER  = 16'd1000;
    localparam logic        RST_TEXT     = 1'b1;
    localparam logic [7:0]  RST_CH_ENABLE = 8'd0;

    localparam logic [SAMPLE_W-1:0] SEPARATOR = 16'hFFFF;

    typedef struct packed {
        logic                  write_valid;
        logic [BUFIDX_W-1:0]   buffer_index;
        logic [SLOT_W-1:0]     slot_index;
        logic [SAMPLE_W-1:0]   word_value;
        logic                  handoff;
        logic                  overflow;
        logic                  last;
    } t_result;

endpackage

### hw/rtl/multi_buffer_sample_packer.sv
// Each item passes through the states in order: a tick item runs the 32-step shift-and-subtract
// remainder unit (skipped with a zero divider), then, if the tick is a sampling tick, retries a
// pending handoff, scans every channel and the separator; take, release and clear items go
// straight to the final result. Output stalls hold the scan and the final result, and a new item
// is accepted only after the previous item has loaded its last result.
// Reset is synchronous and active low; it restores the register defaults and frees every buffer.
module multi_buffer_sample_packer #(
    parameter int CHANNELS         = mbsp_pkg::DEF_CHANNELS,
    parameter int BUFFERS          = mbsp_pkg::DEF_BUFFERS,
    parameter int WORDS_PER_BUFFER = mbsp_pkg::DEF_WORDS_PER_BUFFER
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mbsp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mbsp_pkg::MODE_W-1:0]     i_mode,
    input  logic [mbsp_pkg::TICK_W-1:0]     i_tick,
    input  logic [mbsp_pkg::SEL_W-1:0]      i_buffer_select,
    input  logic                            i_slot_free,
    input  logic [mbsp_pkg::SAMPLE_W-1:0]   i_sample_0,
    input  logic [mbsp_pkg::SAMPLE_W-1:0]   i_sample_1,
    input  logic [mbsp_pkg::SAMPLE_W-1:0]   i_sample_2,
    input  logic [mbsp_pkg::SAMPLE_W-1:0]   i_sample_3,
    input  logic [mbsp_pkg::SAMPLE_W-1:0]   i_sample_4,
    input  logic [mbsp_pkg::SAMPLE_W-1:0]   i_sample_5,
    input  logic [mbsp_pkg::SAMPLE_W-1:0]   i_sample_6,
    input  logic [mbsp_pkg::SAMPLE_W-1:0]   i_sample_7,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_write_valid,
    output logic [mbsp_pkg::BUFIDX_W-1:0]   o_buffer_index,
    output logic [mbsp_pkg::SLOT_W-1:0]     o_slot_index,
    output logic [mbsp_pkg::SAMPLE_W-1:0]   o_word_value,
    output logic                            o_handoff,
    output logic                            o_overflow,
    output logic                            o_last
);
    import mbsp_pkg::*;

    localparam int BUF_W  = $clog2(BUFFERS);
    localparam int FILL_W = $clog2(WORDS_PER_BUFFER + 1);
    localparam int CH_W   = $clog2(CHANNELS + 1);
    localparam int CNT_W  = $clog2(TICK_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_START,
        S_SCAN,
        S_FIN
    } t_state;

    t_state                r_state, n_state;
    logic [15:0]           r_div, n_div;
    logic                  r_text, n_text;
    logic [7:0]            r_chen, n_chen;
    logic [BUF_W-1:0]      r_cur, n_cur;
    logic [FILL_W-1:0]     r_fill, n_fill;
    logic                  r_ovf, n_ovf;
    logic [BUFFERS-1:0]    r_held, n_held;
    logic                  r_pho, n_pho;
    logic                  r_slot_free, n_slot_free;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic [15:0]           r_rem, n_rem;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [CH_W-1:0]       r_ch, n_ch;
    logic [SAMPLE_W-1:0]   r_samp [MAX_CH];
    logic [SAMPLE_W-1:0]   n_samp [MAX_CH];
    t_result               r_pend, n_pend;
    logic                  r_pend_v, n_pend_v;
    t_result               r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic                  out_free;
    logic [16:0]           shifted;
    logic                  ge;
    logic [15:0]           rem_next;
    logic                  has_word;
    logic                  is_sep;
    logic [BUF_W-1:0]      cur_next;
    t_result               res;

    assign out_free = !r_out_valid || i_ready;
    assign shifted  = {r_rem, r_tick[TICK_W-1]};
    assign ge       = shifted >= {1'b0, r_div};
    assign rem_next = ge ? 16'(shifted - {1'b0, r_div}) : shifted[15:0];
    assign is_sep   = r_ch == CH_W'(CHANNELS);
    assign has_word = is_sep ? r_text : r_chen[3'(r_ch)];
    assign cur_next = (r_cur == BUF_W'(BUFFERS - 1)) ? '0 : r_cur + BUF_W'(1);

    always_comb begin
        n_state     = r_state;
        n_div       = r_div;
        n_text      = r_text;
        n_chen      = r_chen;
        n_cur       = r_cur;
        n_fill      = r_fill;
        n_ovf       = r_ovf;
        n_held      = r_held;
        n_pho       = r_pho;
        n_slot_free = r_slot_free;
        n_tick      = r_tick;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_ch        = r_ch;
        n_samp      = r_samp;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        res         = '0;

        if (out_free) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DIVIDER:   n_div  = i_cfg_data;
                CFG_TEXT:      n_text = i_cfg_data[0];
                CFG_CH_ENABLE: n_chen = i_cfg_data[7:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_tick      = i_tick;
                    n_slot_free = i_slot_free;
                    n_samp[0]   = i_sample_0;
                    n_samp[1]   = i_sample_1;
                    n_samp[2]   = i_sample_2;
                    n_samp[3]   = i_sample_3;
                    n_samp[4]   = i_sample_4;
                    n_samp[5]   = i_sample_5;
                    n_samp[6]   = i_sample_6;
                    n_samp[7]   = i_sample_7;
                    n_rem       = '0;
                    n_cnt       = '0;
                    n_pho       = 1'b0;
                    n_pend_v    = 1'b0;
                    n_state     = S_FIN;
                    case (i_mode)
                        MODE_TICK: begin
                            n_state = (r_div == '0) ? S_START : S_DIV;
                        end
                        MODE_TAKE: begin
                            if (32'(i_buffer_select) < BUFFERS) begin
                                n_held[BUF_W'(i_buffer_select)] = 1'b1;
                            end
                        end
                        MODE_RELEASE: begin
                            if (32'(i_buffer_select) < BUFFERS) begin
                                n_held[BUF_W'(i_buffer_select)] = 1'b0;
                            end
                        end
                        MODE_CLEAR: begin
                            n_ovf = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                n_rem  = rem_next;
                n_tick = {r_tick[TICK_W-2:0], 1'b0};
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(TICK_W - 1)) begin
                    n_state = (rem_next == '0) ? S_START : S_FIN;
                end
            end
            S_START: begin
                if (r_fill >= FILL_W'(WORDS_PER_BUFFER)) begin
                    if (r_slot_free) begin
                        n_cur  = cur_next;
                        n_fill = '0;
                        n_pho  = 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                n_ch    = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (out_free) begin
                    if (has_word) begin
                        if (r_fill >= FILL_W'(WORDS_PER_BUFFER) || r_held[r_cur]) begin
                            n_ovf = 1'b1;
                        end else begin
                            res.write_valid  = 1'b1;
                            res.buffer_index = BUFIDX_W'(r_cur);
                            res.slot_index   = SLOT_W'(r_fill);
                            res.word_value   = is_sep ? SEPARATOR : r_samp[3'(r_ch)];
                            res.handoff      = r_pho;
                            n_pho            = 1'b0;
                            n_fill           = r_fill + FILL_W'(1);
                            if (r_fill == FILL_W'(WORDS_PER_BUFFER - 1)) begin
                                if (r_slot_free) begin
                                    n_cur       = cur_next;
                                    n_fill      = '0;
                                    res.handoff = 1'b1;
                                end else begin
                                    n_ovf = 1'b1;
                                end
                            end
                            res.overflow = n_ovf;
                            res.last     = 1'b0;
                            if (r_pend_v) begin
                                n_out       = r_pend;
                                n_out_valid = 1'b1;
                            end
                            n_pend   = res;
                            n_pend_v = 1'b1;
                        end
                    end
                    if (is_sep) begin
                        n_state = S_FIN;
                    end else begin
                        n_ch = r_ch + CH_W'(1);
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    if (r_pend_v) begin
                        n_out      = r_pend;
                        n_out.last = 1'b1;
                    end else begin
                        n_out          = '0;
                        n_out.handoff  = r_pho;
                        n_out.overflow = r_ovf;
                        n_out.last     = 1'b1;
                    end
                    n_out_valid = 1'b1;
                    n_pend_v    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div       <= RST_DIVIDER;
            r_text      <= RST_TEXT;
            r_chen      <= RST_CH_ENABLE;
            r_cur       <= '0;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_held      <= '0;
            r_pho       <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div       <= n_div;
            r_text      <= n_text;
            r_chen      <= n_chen;
            r_cur       <= n_cur;
            r_fill      <= n_fill;
            r_ovf       <= n_ovf;
            r_held      <= n_held;
            r_pho       <= n_pho;
            r_slot_free <= n_slot_free;
            r_tick      <= n_tick;
            r_rem       <= n_rem;
            r_cnt       <= n_cnt;
            r_ch        <= n_ch;
            r_samp      <= n_samp;
            r_pend      <= n_pend;
            r_pend_v    <= n_pend_v;
            r_out       <= n_out;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready        = r_state == S_IDLE;
    assign o_valid        = r_out_valid;
    assign o_write_valid  = r_out.write_valid;
    assign o_buffer_index = r_out.buffer_index;
    assign o_slot_index   = r_out.slot_index;
    assign o_word_value   = r_out.word_value;
    assign o_handoff      = r_out.handoff;
    assign o_overflow     = r_out.overflow;
    assign o_last         = r_out.last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WORDS_PER_BUFFER))
        else $error("Fill position beyond buffer size.");

    a_cur_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur) < BUFFERS)
        else $error("Current buffer outside the ring.");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_pend_v)
        else $error("Pending result left behind at end of item.");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.write_valid |-> r_out.last)
        else $error("Status result that is not the final result of its item.");

    a_div_leaves_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_mode == MODE_TICK && r_div != '0 |=> r_state == S_DIV)
        else $error("Tick transfer did not start the remainder unit.");

endmodule

### bench/multi_buffer_sample_packer_test.sv
module multi_buffer_sample_packer_test;
    import mbsp_pkg::*;

    localparam int CHANNELS         = DEF_CHANNELS;
    localparam int BUFFERS          = DEF_BUFFERS;
    localparam int WORDS_PER_BUFFER = DEF_WORDS_PER_BUFFER;
    localparam int WORDS_PER_SCAN   = MAX_CH + 1;
    localparam int QUIET_LIMIT      = 4000;
    localparam int LONG_HOLD        = 400;
    localparam int SETTLE_CYCLES    = 50;

    typedef struct packed {
        logic [MODE_W-1:0]                mode;
        logic [TICK_W-1:0]                tick;
        logic [SEL_W-1:0]                 sel;
        logic                             slot_free;
        logic [MAX_CH-1:0][SAMPLE_W-1:0]  smp;
    } t_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [MODE_W-1:0]     i_mode = '0;
    logic [TICK_W-1:0]     i_tick = '0;
    logic [SEL_W-1:0]      i_buffer_select = '0;
    logic                  i_slot_free = 1'b0;
    logic [SAMPLE_W-1:0]   i_sample_0 = '0;
    logic [SAMPLE_W-1:0]   i_sample_1 = '0;
    logic [SAMPLE_W-1:0]   i_sample_2 = '0;
    logic [SAMPLE_W-1:0]   i_sample_3 = '0;
    logic [SAMPLE_W-1:0]   i_sample_4 = '0;
    logic [SAMPLE_W-1:0]   i_sample_5 = '0;
    logic [SAMPLE_W-1:0]   i_sample_6 = '0;
    logic [SAMPLE_W-1:0]   i_sample_7 = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_write_valid;
    logic [BUFIDX_W-1:0]   o_buffer_index;
    logic [SLOT_W-1:0]     o_slot_index;
    logic [SAMPLE_W-1:0]   o_word_value;
    logic                  o_handoff;
    logic                  o_overflow;
    logic                  o_last;

    // Register copies and ring state as the block should hold them.
    logic [15:0]           div_reg = RST_DIVIDER;
    logic                  text_reg = RST_TEXT;
    logic [7:0]            chan_en_reg = RST_CH_ENABLE;
    logic [BUFIDX_W-1:0]   ring_buf = '0;
    int                    ring_fill = 0;
    logic                  ovf_flag = 1'b0;
    logic [BUFFERS-1:0]    held = '0;

    t_result               expected_words[$];
    t_result               want;
    t_item                 seen;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_req = 0;
    int          hold_left = 0;
    int          quiet = 0;
    int          failures = 0;
    int          items_accepted = 0;
    int          results_checked = 0;
    int          words_written = 0;
    int          handoffs_seen = 0;
    int          overflow_results = 0;

    multi_buffer_sample_packer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_tick          (i_tick),
        .i_buffer_select (i_buffer_select),
        .i_slot_free     (i_slot_free),
        .i_sample_0      (i_sample_0),
        .i_sample_1      (i_sample_1),
        .i_sample_2      (i_sample_2),
        .i_sample_3      (i_sample_3),
        .i_sample_4      (i_sample_4),
        .i_sample_5      (i_sample_5),
        .i_sample_6      (i_sample_6),
        .i_sample_7      (i_sample_7),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_write_valid   (o_write_valid),
        .o_buffer_index  (o_buffer_index),
        .o_slot_index    (o_slot_index),
        .o_word_value    (o_word_value),
        .o_handoff       (o_handoff),
        .o_overflow      (o_overflow),
        .o_last          (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic next_buffer();
        ring_buf = BUFIDX_W'((ring_buf + 1) % BUFFERS);
        ring_fill = 0;
    endtask

    // Works out the buffer writes and status results that one item causes.
    task automatic pack_scan(input t_item it);
        logic [SAMPLE_W-1:0] words [0:WORDS_PER_SCAN-1];
        int                  nw;
        logic                pend_ho;
        logic                have;
        t_result             r;
        t_result             prev;
        nw = 0;
        pend_ho = 1'b0;
        have = 1'b0;
        prev = '0;
        case (it.mode)
            MODE_TICK: begin
                if (div_reg == 16'd0 || it.tick % {16'd0, div_reg} == 0) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (chan_en_reg[c]) begin
                            words[nw] = it.smp[c];
                            nw++;
                        end
                    end
                    if (text_reg) begin
                        words[nw] = SEPARATOR;
                        nw++;
                    end
                    if (ring_fill >= WORDS_PER_BUFFER) begin
                        if (it.slot_free) begin
                            next_buffer();
                            pend_ho = 1'b1;
                        end else begin
                            ovf_flag = 1'b1;
                        end
                    end
                    for (int w = 0; w < nw; w++) begin
                        if (ring_fill >= WORDS_PER_BUFFER || held[ring_buf]) begin
                            ovf_flag = 1'b1;
                        end else begin
                            r = '0;
                            r.write_valid = 1'b1;
                            r.buffer_index = ring_buf;
                            r.slot_index = ring_fill[SLOT_W-1:0];
                            r.word_value = words[w];
                            r.handoff = pend_ho;
                            pend_ho = 1'b0;
                            ring_fill++;
                            if (ring_fill >= WORDS_PER_BUFFER) begin
                                if (it.slot_free) begin
                                    next_buffer();
                                    r.handoff = 1'b1;
                                end else begin
                                    ovf_flag = 1'b1;
                                end
                            end
                            r.overflow = ovf_flag;
                            if (have) expected_words.push_back(prev);
                            prev = r;
                            have = 1'b1;
                        end
                    end
                end
            end
            MODE_TAKE: held[it.sel] = 1'b1;
            MODE_RELEASE: held[it.sel] = 1'b0;
            MODE_CLEAR: ovf_flag = 1'b0;
            default: ;
        endcase
        if (!have) begin
            prev = '0;
            prev.handoff = pend_ho;
            prev.overflow = ovf_flag;
        end
        prev.last = 1'b1;
        expected_words.push_back(prev);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            seen.mode = i_mode;
            seen.tick = i_tick;
            seen.sel = i_buffer_select;
            seen.slot_free = i_slot_free;
            seen.smp = {i_sample_7, i_sample_6, i_sample_5, i_sample_4,
                        i_sample_3, i_sample_2, i_sample_1, i_sample_0};
            pack_scan(seen);
            items_accepted++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_checked++;
            words_written += int'(o_write_valid);
            handoffs_seen += int'(o_handoff);
            overflow_results += int'(o_overflow);
            if (expected_words.size() == 0) begin
                $error("result transfer with nothing expected");
                failures++;
            end else begin
                want = expected_words.pop_front();
                check_field("write_valid", 32'(want.write_valid), 32'(o_write_valid));
                check_field("buffer_index", 32'(want.buffer_index), 32'(o_buffer_index));
                check_field("slot_index", 32'(want.slot_index), 32'(o_slot_index));
                check_field("word_value", 32'(want.word_value), 32'(o_word_value));
                check_field("handoff", 32'(want.handoff), 32'(o_handoff));
                check_field("overflow", 32'(want.overflow), 32'(o_overflow));
                check_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("** multi_buffer_sample_packer: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_DIVIDER: div_reg = data;
            CFG_TEXT: text_reg = data[0];
            CFG_CH_ENABLE: chan_en_reg = data[7:0];
            default: ;
        endcase
    endtask

    task automatic send_item(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= it.mode;
        i_tick <= it.tick;
        i_buffer_select <= it.sel;
        i_slot_free <= it.slot_free;
        i_sample_0 <= it.smp[0];
        i_sample_1 <= it.smp[1];
        i_sample_2 <= it.smp[2];
        i_sample_3 <= it.smp[3];
        i_sample_4 <= it.smp[4];
        i_sample_5 <= it.smp[5];
        i_sample_6 <= it.smp[6];
        i_sample_7 <= it.smp[7];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_item tick_item(input logic [TICK_W-1:0] tick,
                                        input logic [SAMPLE_W-1:0] pattern,
                                        input logic slot_free);
        t_item it;
        it = '0;
        it.mode = MODE_TICK;
        it.tick = tick;
        it.sel = SEL_W'($urandom);
        it.slot_free = slot_free;
        for (int c = 0; c < MAX_CH; c++) it.smp[c] = pattern ^ SAMPLE_W'(c * 16'h1111);
        return it;
    endfunction

    function automatic t_item control_item(input logic [MODE_W-1:0] mode,
                                           input logic [SEL_W-1:0] sel);
        t_item it;
        it = tick_item($urandom, SAMPLE_W'($urandom), 1'($urandom));
        it.mode = mode;
        it.sel = sel;
        return it;
    endfunction

    function automatic t_item random_item();
        t_item       it;
        int unsigned pick;
        int unsigned step;
        it.tick = $urandom;
        it.sel = SEL_W'($urandom);
        it.slot_free = ($urandom_range(99) < 75);
        for (int c = 0; c < MAX_CH; c++) it.smp[c] = SAMPLE_W'($urandom);
        step = (div_reg == 16'd0) ? 32'd1 : 32'(div_reg);
        if ($urandom_range(1) == 1) it.tick = it.tick - it.tick % step;
        pick = $urandom_range(99);
        if (pick < 83) it.mode = MODE_TICK;
        else if (pick < 87) it.mode = MODE_TAKE;
        else if (pick < 95) it.mode = MODE_RELEASE;
        else it.mode = MODE_CLEAR;
        return it;
    endfunction

    task automatic random_config();
        write_reg(CFG_DIVIDER, CFG_DATA_W'($urandom_range(3, 1)));
        write_reg(CFG_TEXT, CFG_DATA_W'($urandom));
        write_reg(CFG_CH_ENABLE, CFG_DATA_W'($urandom));
    endtask

    task automatic random_burst(input int count, input int unsigned send_pct,
                                input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        random_config();
        for (int k = 0; k < count; k++) send_item(random_item());
        wait_for_drain();
    endtask

    task automatic test_reset_values();
        send_item(tick_item(32'd0, 16'h0000, 1'b1));
        send_item(tick_item(32'd999, 16'h1234, 1'b1));
        send_item(tick_item(32'd2000, 16'hFFFF, 1'b1));
        send_item(tick_item(32'hFFFF_FFFF, 16'h4321, 1'b1));
        send_item(control_item(MODE_CLEAR, 2'd0));
        wait_for_drain();
    endtask

    task automatic test_special_cases();
        write_reg(CFG_DIVIDER, 16'd1);
        write_reg(CFG_TEXT, 16'd1);
        write_reg(CFG_CH_ENABLE, 16'h00FF);
        send_item(tick_item(32'd5, 16'h0000, 1'b1));
        send_item(tick_item(32'd6, 16'hFFFF, 1'b1));
        send_item(tick_item(32'd7, 16'h5A5A, 1'b0));
        send_item(control_item(MODE_TAKE, 2'd0));
        send_item(tick_item(32'd8, 16'hA5A5, 1'b1));
        send_item(control_item(MODE_CLEAR, 2'd0));
        send_item(control_item(MODE_RELEASE, 2'd0));
        send_item(tick_item(32'd9, 16'h00FF, 1'b1));
        send_item(control_item(MODE_TAKE, 2'd3));
        send_item(control_item(MODE_RELEASE, 2'd3));
        wait_for_drain();
        write_reg(CFG_TEXT, 16'hFFFE);
        write_reg(CFG_CH_ENABLE, 16'hFF00);
        send_item(tick_item(32'd10, 16'h7777, 1'b1));
        wait_for_drain();
        write_reg(CFG_CH_ENABLE, 16'h0081);
        send_item(tick_item(32'd11, 16'h8888, 1'b1));
        wait_for_drain();
        write_reg(CFG_DIVIDER, 16'd0);
        send_item(tick_item(32'h1234_5677, 16'hC3C3, 1'b1));
        wait_for_drain();
        write_reg(CFG_DIVIDER, 16'hFFFF);
        write_reg(CFG_TEXT, 16'd1);
        write_reg(CFG_CH_ENABLE, 16'h00FF);
        send_item(tick_item(32'd196605, 16'h3C3C, 1'b1));
        send_item(tick_item(32'd65534, 16'h0F0F, 1'b1));
        send_item(tick_item(32'hFFFF_FFFF, 16'hF0F0, 1'b1));
        wait_for_drain();
    endtask

    // Fills the current buffer with no handoff slot, keeps scanning while it is
    // stuck, then lets the retried handoff through.
    task automatic test_full_buffer_retry();
        int scans;
        write_reg(CFG_DIVIDER, 16'd1);
        write_reg(CFG_TEXT, 16'd1);
        write_reg(CFG_CH_ENABLE, 16'h00FF);
        scans = (WORDS_PER_BUFFER - ring_fill + WORDS_PER_SCAN - 1) / WORDS_PER_SCAN + 2;
        for (int k = 0; k < scans; k++) send_item(tick_item($urandom, SAMPLE_W'($urandom), 1'b0));
        send_item(tick_item($urandom, SAMPLE_W'($urandom), 1'b1));
        send_item(control_item(MODE_CLEAR, 2'd1));
        send_item(tick_item($urandom, SAMPLE_W'($urandom), 1'b1));
        wait_for_drain();
    endtask

    task automatic test_output_hold();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_config();
        hold_req = LONG_HOLD;
        for (int k = 0; k < 8; k++) send_item(random_item());
        wait_for_drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_special_cases();
        test_full_buffer_retry();
        random_burst(16, 86, 0);
        random_burst(16, 0, 86);
        random_burst(16, 20, 20);
        test_output_hold();
        random_burst(10, 0, 0);
        $display("Checked %0d results from %0d items: %0d buffer words, %0d handoffs.",
                 results_checked, items_accepted, words_written, handoffs_seen);
        $display("Overflow was flagged on %0d results across directed, full-buffer, stall and hold runs.",
                 overflow_results);
        if (failures == 0) begin
            $display("** multi_buffer_sample_packer: PASSED **");
        end else begin
            $display("** multi_buffer_sample_packer: FAILED **");
        end
        $finish;
    end

endmodule
